>>> sv/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// shared types, codes and token tables for the modem response parser
// ----------------------------------------------------------------------------
package arp_pkg;

    // line position wraps here
    localparam logic [7:0] LINE_BUF_SIZE = 8'd255;

    // parse modes
    localparam logic [2:0] MODE_DETECT       = 3'd0;
    localparam logic [2:0] MODE_ECHO         = 3'd1;
    localparam logic [2:0] MODE_ACT_TYPE     = 3'd2;
    localparam logic [2:0] MODE_ACT_RESULT   = 3'd3;
    localparam logic [2:0] MODE_ACT_LENGTH   = 3'd4;
    localparam logic [2:0] MODE_READ_LENGTH  = 3'd5;
    localparam logic [2:0] MODE_READ_CONTENT = 3'd6;
    localparam logic [2:0] MODE_ERROR        = 3'd7;

    // number scanner states
    localparam logic [1:0] NUM_NONE = 2'd0;
    localparam logic [1:0] NUM_IN   = 2'd1;
    localparam logic [1:0] NUM_DONE = 2'd2;

    // event kinds
    localparam logic [1:0] EV_CONTENT  = 2'd0;
    localparam logic [1:0] EV_READ_REQ = 2'd1;
    localparam logic [1:0] EV_READ_HDR = 2'd2;
    localparam logic [1:0] EV_ERROR    = 2'd3;

    // match flag bits
    localparam int FLG_ECHO   = 0;
    localparam int FLG_ACTION = 1;
    localparam int FLG_READ   = 2;
    localparam int FLG_ERROR  = 3;

    // characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // tokens, left aligned in 12 characters
    localparam logic [95:0] TOK_ECHO   = {"AT+", 72'h0};
    localparam logic [95:0] TOK_ACTION = "+HTTPACTION:";
    localparam logic [95:0] TOK_READ   = {"+HTTPREAD:", 16'h0};
    localparam logic [95:0] TOK_ERROR  = {"+CME ERROR:", 8'h0};

    localparam logic [3:0] LEN_ECHO   = 4'd3;
    localparam logic [3:0] LEN_ACTION = 4'd12;
    localparam logic [3:0] LEN_READ   = 4'd10;
    localparam logic [3:0] LEN_ERROR  = 4'd11;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  pos;
        logic [3:0]  flags;
        logic [15:0] acc;
        logic [1:0]  digits;
        logic [15:0] remain;
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic [15:0] length;
        logic        last;
    } t_result;

    // true when byte b equals the token character at position pos
    function automatic logic f_tok_hit(input logic [95:0] text, input logic [3:0] len,
                                       input logic [7:0] pos, input logic [7:0] b);
        logic [95:0] sh;
        logic        hit;
        sh  = text << {pos[3:0], 3'b000};
        hit = (pos < {4'd0, len}) && (sh[95:88] == b);
        return hit;
    endfunction

endpackage

>>> sv/arp_step.sv
// ----------------------------------------------------------------------------
// arp_step
// next parse state and optional event for one received byte
// ----------------------------------------------------------------------------
module arp_step (
    input  arp_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    output arp_pkg::t_state  o_state,
    output logic             o_has_event,
    output arp_pkg::t_result o_event
);
    import arp_pkg::*;

    always_comb begin
        t_state      st;
        t_result     ev;
        logic        has;
        logic        digit;
        logic        blank;
        logic [3:0]  d;
        logic [19:0] mac;
        logic [7:0]  pos_inc;
        logic        restart;
        logic        done_echo;
        logic        done_action;
        logic        done_read;
        logic        done_error;

        st    = i_state;
        ev    = '0;
        has   = 1'b0;
        digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        blank = (i_byte == 8'h20) || ((i_byte >= 8'h09) && (i_byte <= 8'h0D));
        d     = i_byte[3:0];
        mac   = ({4'd0, i_state.acc} << 3) + ({4'd0, i_state.acc} << 1) + {16'd0, d};

        // prefix match
        if (!f_tok_hit(TOK_ECHO, LEN_ECHO, i_state.pos, i_byte))
            st.flags[FLG_ECHO] = 1'b0;
        if (!f_tok_hit(TOK_ACTION, LEN_ACTION, i_state.pos, i_byte))
            st.flags[FLG_ACTION] = 1'b0;
        if (!f_tok_hit(TOK_READ, LEN_READ, i_state.pos, i_byte))
            st.flags[FLG_READ] = 1'b0;
        if (!f_tok_hit(TOK_ERROR, LEN_ERROR, i_state.pos, i_byte))
            st.flags[FLG_ERROR] = 1'b0;

        // leading decimal number
        case (i_state.digits)
            NUM_NONE: begin
                if (!blank) begin
                    if (i_byte == CH_PLUS) begin
                        st.digits = NUM_IN;
                    end else if (digit) begin
                        st.digits = NUM_IN;
                        st.acc    = {12'd0, d};
                    end else begin
                        st.digits = NUM_DONE;
                        st.acc    = '0;
                    end
                end
            end
            NUM_IN: begin
                if (digit) begin
                    st.acc = (mac > 20'd65535) ? 16'hFFFF : mac[15:0];
                end else begin
                    st.digits = NUM_DONE;
                end
            end
            default: begin
            end
        endcase

        // position, with wrap at the buffer size
        pos_inc = i_state.pos + 8'd1;
        if (pos_inc >= LINE_BUF_SIZE) begin
            st.pos    = '0;
            st.flags  = '1;
            st.acc    = '0;
            st.digits = NUM_NONE;
        end else begin
            st.pos = pos_inc;
        end

        done_echo   = st.flags[FLG_ECHO]   && (st.pos == {4'd0, LEN_ECHO});
        done_action = st.flags[FLG_ACTION] && (st.pos == {4'd0, LEN_ACTION});
        done_read   = st.flags[FLG_READ]   && (st.pos == {4'd0, LEN_READ});
        done_error  = st.flags[FLG_ERROR]  && (st.pos == {4'd0, LEN_ERROR});

        restart = 1'b0;
        case (i_state.mode)
            MODE_DETECT: begin
                if (i_byte == CH_LF) begin
                    restart = 1'b1;
                end else if (done_echo) begin
                    st.mode = MODE_ECHO;
                end else if (i_byte == CH_COLON) begin
                    if (done_action) begin
                        st.mode = MODE_ACT_TYPE;
                    end else if (done_read) begin
                        st.mode = MODE_READ_LENGTH;
                    end else if (done_error) begin
                        st.mode = MODE_ERROR;
                        ev.kind = EV_ERROR;
                        has     = 1'b1;
                    end
                    restart = 1'b1;
                end
            end
            MODE_ECHO, MODE_ERROR: begin
                if (i_byte == CH_LF) begin
                    st.mode = MODE_DETECT;
                    restart = 1'b1;
                end
            end
            MODE_ACT_TYPE: begin
                if (i_byte == CH_COMMA) begin
                    st.mode = MODE_ACT_RESULT;
                    restart = 1'b1;
                end
            end
            MODE_ACT_RESULT: begin
                if (i_byte == CH_COMMA) begin
                    st.mode = MODE_ACT_LENGTH;
                    restart = 1'b1;
                end
            end
            MODE_ACT_LENGTH: begin
                if (i_byte == CH_LF) begin
                    ev.kind   = EV_READ_REQ;
                    ev.length = st.acc;
                    has       = 1'b1;
                    st.mode   = MODE_DETECT;
                    restart   = 1'b1;
                end
            end
            MODE_READ_LENGTH: begin
                if (i_byte == CH_LF) begin
                    ev.kind   = EV_READ_HDR;
                    ev.length = st.acc;
                    has       = 1'b1;
                    st.remain = st.acc;
                    st.mode   = MODE_READ_CONTENT;
                    restart   = 1'b1;
                end
            end
            default: begin
                ev.kind    = EV_CONTENT;
                ev.payload = i_byte;
                has        = 1'b1;
                if (i_state.remain <= 16'd1) begin
                    ev.last   = 1'b1;
                    st.remain = '0;
                    st.mode   = MODE_DETECT;
                    restart   = 1'b1;
                end else begin
                    st.remain = i_state.remain - 16'd1;
                end
            end
        endcase

        if (restart) begin
            st.pos    = '0;
            st.flags  = '1;
            st.acc    = '0;
            st.digits = NUM_NONE;
        end

        o_state     = st;
        o_event     = ev;
        o_has_event = has;
    end

endmodule

>>> sv/at_response_parser.sv
// ----------------------------------------------------------------------------
// at_response_parser
// modem response byte parser: error lines, http read requests, read headers and content
// ----------------------------------------------------------------------------
// usage
//   rx channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one response byte
//   per beat; the ev channel (o_ev_valid / i_ev_ready) gives at most one
//   event beat per byte: a content byte, a read request with length, a read
//   header length, or a modem error line
//   bytes that cause no event are absorbed without an output beat
// timing
//   one byte per cycle sustained while i_ev_ready stays high; the byte sits
//   in an input register, is parsed by the combinational next-state logic
//   and lands in the event register, which drives the event beat
// reset
//   i_rst_n low clears both registers' valid bits and puts the parser in
//   detect mode at line start with a zero length
// stall
//   while i_ev_ready is low with an event waiting, one more byte is held in
//   the input register and o_rx_ready drops until the event beat is taken
// ----------------------------------------------------------------------------
module at_response_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_ev_valid,
    input  logic        i_ev_ready,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_length_value,
    output logic        o_last_byte
);
    import arp_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // parser state
    t_state     r_state;
    t_state     n_state;

    // event register
    logic       r_out_valid;
    t_result    r_out;

    logic       n_has_event;
    t_result    n_event;
    logic       step;

    // the held byte is parsed once the event register can take its result
    assign step       = r_in_valid && (!r_out_valid || i_ev_ready);
    assign o_rx_ready = !r_in_valid || step;

    arp_step u_step (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .o_state     (n_state),
        .o_has_event (n_has_event),
        .o_event     (n_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode   <= MODE_DETECT;
            r_state.pos    <= '0;
            r_state.flags  <= '1;
            r_state.acc    <= '0;
            r_state.digits <= NUM_NONE;
            r_state.remain <= '0;
        end else if (step) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= n_has_event;
        end else if (i_ev_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && n_has_event) begin
            r_out <= n_event;
        end
    end

    assign o_ev_valid     = r_out_valid;
    assign o_event_kind   = r_out.kind;
    assign o_payload_byte = r_out.payload;
    assign o_length_value = r_out.length;
    assign o_last_byte    = r_out.last;

endmodule

>>> tb/arp_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_event_checker
// watches both channels of the response parser, predicts every event beat
// from the accepted bytes and compares it field by field
// ----------------------------------------------------------------------------
module arp_event_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_ev_valid,
    input  logic        i_ev_ready,
    input  logic [1:0]  i_event_kind,
    input  logic [7:0]  i_payload_byte,
    input  logic [15:0] i_length_value,
    input  logic        i_last_byte,
    output int          o_error_count,
    output int          o_pending
);
    import arp_pkg::*;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_DIGIT9 = 8'h39;

    // tracked parser state
    logic [2:0]  track_mode;
    logic [7:0]  track_pos;
    logic [3:0]  track_flags;
    logic [15:0] track_acc;
    logic [1:0]  track_digits;
    logic [15:0] track_left;

    t_result     expected_events[$];
    t_result     next_event;
    t_result     oldest_event;
    bit          has_event;

    function automatic int token_len(input int k);
        case (k)
            FLG_ECHO:   return int'(LEN_ECHO);
            FLG_ACTION: return int'(LEN_ACTION);
            FLG_READ:   return int'(LEN_READ);
            default:    return int'(LEN_ERROR);
        endcase
    endfunction

    // character p of token k, tokens are left aligned in 96 bits
    function automatic logic [7:0] token_char(input int k, input int p);
        logic [95:0] text;
        case (k)
            FLG_ECHO:   text = TOK_ECHO;
            FLG_ACTION: text = TOK_ACTION;
            FLG_READ:   text = TOK_READ;
            default:    text = TOK_ERROR;
        endcase
        return text[95 - 8 * p -: 8];
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic bit token_done(input int k);
        return track_flags[k] && (int'(track_pos) == token_len(k));
    endfunction

    task automatic restart_line();
        track_pos    = 8'd0;
        track_flags  = 4'hF;
        track_acc    = 16'd0;
        track_digits = NUM_NONE;
    endtask

    task automatic scan_number(input logic [7:0] b);
        logic        is_digit;
        logic [31:0] grown;
        is_digit = (b >= CH_DIGIT0) && (b <= CH_DIGIT9);
        if (track_digits == NUM_NONE) begin
            if (!is_blank(b)) begin
                if (b == CH_PLUS) begin
                    track_digits = NUM_IN;
                end else if (is_digit) begin
                    track_digits = NUM_IN;
                    track_acc    = {8'd0, b - CH_DIGIT0};
                end else begin
                    track_digits = NUM_DONE;
                    track_acc    = 16'd0;
                end
            end
        end else if (track_digits == NUM_IN) begin
            if (is_digit) begin
                grown     = track_acc * 32'd10 + (b - CH_DIGIT0);
                track_acc = (grown > 32'd65535) ? 16'hFFFF : grown[15:0];
            end else begin
                track_digits = NUM_DONE;
            end
        end
    endtask

    // advance the tracked parser by one byte, give the event it causes
    task automatic parse_rx_byte(input logic [7:0] b, output bit produced,
                                 output t_result ev);
        int p;
        produced = 1'b0;
        ev       = '0;
        p        = int'(track_pos);
        for (int k = 0; k < 4; k++) begin
            if (p >= token_len(k)) begin
                track_flags[k] = 1'b0;
            end else if (token_char(k, p) != b) begin
                track_flags[k] = 1'b0;
            end
        end
        scan_number(b);
        p = p + 1;
        // line overflow drops what was gathered before the byte is used
        if (p >= int'(LINE_BUF_SIZE)) begin
            restart_line();
        end else begin
            track_pos = p[7:0];
        end

        case (track_mode)
            MODE_DETECT: begin
                if (b == CH_LF) begin
                    restart_line();
                end else if (token_done(FLG_ECHO)) begin
                    track_mode = MODE_ECHO;
                end else if (b == CH_COLON) begin
                    if (token_done(FLG_ACTION)) begin
                        track_mode = MODE_ACT_TYPE;
                    end else if (token_done(FLG_READ)) begin
                        track_mode = MODE_READ_LENGTH;
                    end else if (token_done(FLG_ERROR)) begin
                        track_mode = MODE_ERROR;
                        ev.kind    = EV_ERROR;
                        produced   = 1'b1;
                    end
                    restart_line();
                end
            end
            MODE_ECHO, MODE_ERROR: begin
                if (b == CH_LF) begin
                    track_mode = MODE_DETECT;
                    restart_line();
                end
            end
            MODE_ACT_TYPE: begin
                if (b == CH_COMMA) begin
                    track_mode = MODE_ACT_RESULT;
                    restart_line();
                end
            end
            MODE_ACT_RESULT: begin
                if (b == CH_COMMA) begin
                    track_mode = MODE_ACT_LENGTH;
                    restart_line();
                end
            end
            MODE_ACT_LENGTH: begin
                if (b == CH_LF) begin
                    ev.kind    = EV_READ_REQ;
                    ev.length  = track_acc;
                    produced   = 1'b1;
                    track_mode = MODE_DETECT;
                    restart_line();
                end
            end
            MODE_READ_LENGTH: begin
                if (b == CH_LF) begin
                    ev.kind    = EV_READ_HDR;
                    ev.length  = track_acc;
                    produced   = 1'b1;
                    track_left = track_acc;
                    track_mode = MODE_READ_CONTENT;
                    restart_line();
                end
            end
            default: begin
                ev.kind    = EV_CONTENT;
                ev.payload = b;
                produced   = 1'b1;
                // a zero count still takes one byte
                if (track_left <= 16'd1) begin
                    ev.last    = 1'b1;
                    track_left = 16'd0;
                    track_mode = MODE_DETECT;
                    restart_line();
                end else begin
                    track_left = track_left - 16'd1;
                end
            end
        endcase
    endtask

    task automatic check_field(input string what, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
            o_error_count = o_error_count + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            track_mode = MODE_DETECT;
            track_left = 16'd0;
            restart_line();
            expected_events.delete();
        end else begin
            if (i_rx_valid && i_rx_ready) begin
                parse_rx_byte(i_rx_byte, has_event, next_event);
                if (has_event) begin
                    expected_events.push_back(next_event);
                end
            end
            if (i_ev_valid && i_ev_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: event beat expected none actual kind %0d len %0d",
                             $time, i_event_kind, i_length_value);
                    o_error_count = o_error_count + 1;
                end else begin
                    oldest_event = expected_events.pop_front();
                    check_field("kind", {14'd0, oldest_event.kind}, {14'd0, i_event_kind});
                    check_field("payload", {8'd0, oldest_event.payload},
                                {8'd0, i_payload_byte});
                    check_field("length", oldest_event.length, i_length_value);
                    check_field("last", {15'd0, oldest_event.last}, {15'd0, i_last_byte});
                end
            end
        end
        o_pending = expected_events.size();
    end

endmodule

>>> tb/at_response_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// at_response_parser_test
// drives modem response text into the parser and lets the checker compare
// every event beat; directed lines first, then random messages and noise
// ----------------------------------------------------------------------------
module at_response_parser_test;

    import arp_pkg::*;

    localparam int RANDOM_BYTES = 400;

    logic        clk;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_ready;
    logic [7:0]  rx_byte;
    logic        ev_valid;
    logic        ev_ready;
    logic [1:0]  ev_kind;
    logic [7:0]  ev_payload;
    logic [15:0] ev_length;
    logic        ev_last;

    int          error_count;
    int          pending;
    int          bytes_sent;
    int          msg_count;
    logic        no_idle;

    at_response_parser dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_ev_valid     (ev_valid),
        .i_ev_ready     (ev_ready),
        .o_event_kind   (ev_kind),
        .o_payload_byte (ev_payload),
        .o_length_value (ev_length),
        .o_last_byte    (ev_last)
    );

    arp_event_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .i_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .i_ev_valid     (ev_valid),
        .i_ev_ready     (ev_ready),
        .i_event_kind   (ev_kind),
        .i_payload_byte (ev_payload),
        .i_length_value (ev_length),
        .i_last_byte    (ev_last),
        .o_error_count  (error_count),
        .o_pending      (pending)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // event sink stalls at random, about 14 percent of the time, none in the quiet stretch
    always @(posedge clk) begin
        ev_ready <= no_idle || ($urandom_range(99) >= 14);
    end

    // one rx beat; called right after a rising edge, returns right after the
    // edge that accepted it; ready is sampled on the falling edge
    task automatic send_byte(input logic [7:0] b);
        bit hit;
        while (!no_idle && ($urandom_range(99) < 14)) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do begin
            @(negedge clk);
            hit = rx_ready;
            @(posedge clk);
        end while (!hit);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // read content: a zero count still consumes one byte
    task automatic send_payload(input int unsigned count);
        int unsigned n;
        n = (count == 0) ? 1 : count;
        repeat (n) send_byte(8'($urandom_range(255)));
    endtask

    function automatic string add_char(input string s, input logic [7:0] c);
        return $sformatf("%s%c", s, c);
    endfunction

    // printable filler with no line end and no colon
    function automatic string filler(input int n);
        string       s;
        logic [7:0]  c;
        s = "";
        for (int i = 0; i < n; i++) begin
            c = 8'($urandom_range(32, 126));
            if (c == CH_COLON) c = "x";
            s = add_char(s, c);
        end
        return s;
    endfunction

    // length field in one of several spellings, gives what the parser reads
    function automatic string length_text(input int unsigned value,
                                          output int unsigned parsed);
        string s;
        int    form;
        s = "";
        repeat ($urandom_range(2)) begin
            case ($urandom_range(4))
                0: s = add_char(s, 8'h20);
                1: s = add_char(s, 8'h09);
                2: s = add_char(s, 8'h0B);
                3: s = add_char(s, 8'h0C);
                default: s = add_char(s, 8'h0D);
            endcase
        end
        form   = $urandom_range(9);
        parsed = (value > 65535) ? 65535 : value;
        case (form)
            0: begin
                // negative number reads as zero
                s      = $sformatf("%s-%0d", s, value);
                parsed = 0;
            end
            1: parsed = 0;
            2: s = $sformatf("%s+%0d", s, value);
            3: s = $sformatf("%s00%0d", s, value);
            4: s = $sformatf("%s%0dab,7", s, value);
            default: s = $sformatf("%s%0d", s, value);
        endcase
        return s;
    endfunction

    task automatic send_action(input int unsigned value);
        int unsigned parsed;
        string       s;
        s = $sformatf("+HTTPACTION:%s%0d,%0d,", ($urandom_range(1) != 0) ? " " : "",
                      $urandom_range(2), $urandom_range(100, 699));
        s = {s, length_text(value, parsed), "\r\n"};
        send_text(s);
    endtask

    task automatic send_read(input int unsigned value);
        int unsigned parsed;
        string       s;
        s = {"+HTTPREAD:", length_text(value, parsed), "\r\n"};
        send_text(s);
        send_payload(parsed);
    endtask

    task automatic send_random_message();
        int          pick;
        int unsigned value;
        string       s;
        pick = $urandom_range(99);
        if (pick < 25) begin
            case ($urandom_range(4))
                0: value = $urandom_range(60000, 70000);
                1: value = $urandom;
                default: value = $urandom_range(2000);
            endcase
            send_action(value);
        end else if (pick < 55) begin
            value = ($urandom_range(9) < 8) ? $urandom_range(12) : $urandom_range(13, 60);
            send_read(value);
        end else if (pick < 63) begin
            send_text($sformatf("+CME ERROR: %0d\r\n", $urandom_range(999)));
        end else if (pick < 72) begin
            if ($urandom_range(1) != 0) begin
                send_text($sformatf("AT+HTTPREAD=0,%0d\r\n", $urandom_range(500)));
            end else begin
                send_text({"AT+", filler($urandom_range(12)), "\r\n"});
            end
        end else if (pick < 79) begin
            // unknown or near-miss token
            case ($urandom_range(2))
                0: s = "+HTTPREAX:";
                1: s = "+HTTPACTIO:";
                default: s = {"+", filler($urandom_range(1, 6)), ":"};
            endcase
            send_text({s, filler($urandom_range(6)), "\r\n"});
        end else if (pick < 87) begin
            // broken message: cut short, then a line end
            case ($urandom_range(2))
                0: s = $sformatf("+HTTPACTION:0,200,%0d\r\n", $urandom_range(9999));
                1: s = $sformatf("+HTTPREAD:%0d\r\n", $urandom_range(20));
                default: s = "+CME ERROR: 50\r\n";
            endcase
            send_text({s.substr(0, $urandom_range(s.len() - 2)), "\r\n"});
        end else if (pick < 96) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
        end else begin
            // lines around the buffer size
            if ($urandom_range(1) != 0) begin
                send_text({filler($urandom_range(250, 262)), "\r\n"});
            end else begin
                send_text({"+HTTPACTION:0,200,", filler($urandom_range(235, 250)),
                           $sformatf("%0d\r\n", $urandom_range(99))});
            end
        end
    endtask

    // run limit, far above the slowest correct run
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        rst_n      = 1'b0;
        rx_valid   = 1'b0;
        rx_byte    = 8'h00;
        no_idle    = 1'b0;
        bytes_sent = 0;
        msg_count  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines
        send_text("\r\n");
        send_text("AT+HTTPACTION=0\r\n");
        send_text("+HTTPACTION: 0,200,1234\r\n");
        send_text("+HTTPACTION:0,200, \t+00065535\r\n");
        send_text("+HTTPACTION:0,200,999999\r\n");
        send_text("+HTTPACTION:0,200,-17\r\n");
        send_text("+HTTPACTION:0,404,\r\n");
        send_text("+HTTPACTION:0,200,12ab34\r\n");
        send_text("+HTTPACTION:0,200,0\r\n");
        send_text("+HTTPREAD:3\r\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h0A);
        send_text("+HTTPREAD:0\r\n");
        send_byte(8'h3A);
        send_text("+HTTPREAD:-2\r\n");
        send_byte(8'h55);
        send_text("+HTTPREAD:\r\n");
        send_byte(8'hAA);
        send_text("+CME ERROR: 3\r\n");
        send_text("+FOO:bar\r\n");
        send_text("AT+HTTPREAD=0,10\r\n");
        // overflow drops the length gathered before the wrap
        send_text({"+HTTPREAD:5", filler(0)});
        repeat (260) send_byte(8'h20);
        send_text("\r\n");
        send_byte(8'h7E);
        send_text({filler(300), "\r\n"});

        // random messages, one quiet stretch and one drain pause
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            no_idle <= (bytes_sent >= 150) && (bytes_sent < 300);
            send_random_message();
            msg_count = msg_count + 1;
            if (msg_count == 1) begin
                rx_valid <= 1'b0;
                do @(negedge clk); while (pending != 0);
                @(posedge clk);
            end
        end

        // drain and let the pipeline settle
        rx_valid <= 1'b0;
        no_idle  <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (16) @(posedge clk);
        @(negedge clk);
        if (error_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
